@@ src/sonar_mofn_pkg.sv @@
// ----------------------------------------------------------------------------
// sonar_mofn_pkg
// Shared types and constants for the sonar M-of-N obstacle detector:
// beat structs, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package sonar_mofn_pkg;

    // Field widths fixed by the interface
    localparam int DIST_W    = 16;
    localparam int MATCH_W   = 4;
    localparam int HOLDOFF_W = 7;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Operation codes carried in the op field
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIST_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd3;

    // Input beat
    typedef struct packed {
        logic              op;
        logic [DIST_W-1:0] distance;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic sample_taken;
        logic obstacle_found;
        logic stop_robot;
        logic request_armed;
    } out_item_t;

endpackage

@@ src/sonar_m_of_n_obstacle_detector.sv @@
// ----------------------------------------------------------------------------
// sonar_m_of_n_obstacle_detector
// Tick-paced sample gating and M-of-N near-distance detection over a ring
// of recent sonar distances held in a synchronous memory with one write and one read port.
// ----------------------------------------------------------------------------
// A tick beat or a dropped sample (no request armed) is answered straight from
// the idle state. A stored sample is accepted and written into the ring; the
// ring of HISTORY_DEPTH entries (8 by default) is then walked through the
// memory read port one entry per cycle, and the result is compared and posted
// once the output register is free. A new beat is accepted whenever the block
// is idle and the output register is empty or being drained in the same cycle.
// Reset clears the ring at once through per-entry valid bits, so there is no
// clearing pass.
// ----------------------------------------------------------------------------
module sonar_m_of_n_obstacle_detector #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  sonar_mofn_pkg::in_item_t                s_data,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output sonar_mofn_pkg::out_item_t               m_data,

    input  logic                                    cfg_wr_en,
    input  logic [sonar_mofn_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [sonar_mofn_pkg::CFG_DAT_W-1:0]    cfg_wr_data
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > sonar_mofn_pkg::MATCH_W) ? CNT_W
                                                             : sonar_mofn_pkg::MATCH_W;
    localparam int DW     = sonar_mofn_pkg::DIST_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL
    } state_t;

    // Control state
    state_t                               state_reg,   state_next;
    logic [DW-1:0]                        dist_thr_reg, dist_thr_next;
    logic [sonar_mofn_pkg::MATCH_W-1:0]   match_thr_reg, match_thr_next;
    logic [sonar_mofn_pkg::HOLDOFF_W-1:0] holdoff_ticks_reg, holdoff_ticks_next;
    logic                                 enable_reg,  enable_next;
    logic [SLOT_W-1:0]                    slot_reg,    slot_next;
    logic [sonar_mofn_pkg::TICK_W-1:0]    tick_reg,    tick_next;
    logic [sonar_mofn_pkg::HOLDOFF_W-1:0] holdoff_reg, holdoff_next;
    logic                                 request_reg, request_next;
    logic [HISTORY_DEPTH-1:0]             vld_reg,     vld_next;
    logic [CNT_W-1:0]                     scan_reg,    scan_next;
    logic [CNT_W-1:0]                     near_reg,    near_next;
    logic                                 rd_pend_reg, rd_pend_next;
    logic                                 m_valid_reg, m_valid_next;
    sonar_mofn_pkg::out_item_t            m_data_reg,  m_data_next;

    // History memory and its registered read port
    logic [DW-1:0]                        hist_mem [HISTORY_DEPTH];
    logic [DW-1:0]                        rd_data_reg;
    logic                                 rd_vld_reg;

    logic                                 out_free;
    logic                                 accept;
    logic                                 mem_we;
    logic                                 rd_en;
    logic [SLOT_W-1:0]                    rd_addr;
    logic                                 hit;
    logic                                 found;
    logic [sonar_mofn_pkg::TICK_W-1:0]    tick_inc;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign rd_addr  = scan_reg[SLOT_W-1:0];
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Near test on the entry returned by the memory
    assign hit = rd_pend_reg && rd_vld_reg && (rd_data_reg != '0)
                 && (rd_data_reg < dist_thr_reg);
    assign found = (CMP_W'(near_reg) >= CMP_W'(match_thr_reg));
    assign tick_inc = tick_reg + 1'b1;

    // Next-state logic
    always_comb begin
        state_next         = state_reg;
        dist_thr_next      = dist_thr_reg;
        match_thr_next     = match_thr_reg;
        holdoff_ticks_next = holdoff_ticks_reg;
        enable_next        = enable_reg;
        slot_next          = slot_reg;
        tick_next          = tick_reg;
        holdoff_next       = holdoff_reg;
        request_next       = request_reg;
        vld_next           = vld_reg;
        scan_next          = scan_reg;
        near_next          = near_reg;
        rd_pend_next       = 1'b0;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;
        mem_we             = 1'b0;
        rd_en              = 1'b0;

        // Result register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                sonar_mofn_pkg::REG_DIST_THR:  dist_thr_next = cfg_wr_data[DW-1:0];
                sonar_mofn_pkg::REG_MATCH_THR:
                    match_thr_next = cfg_wr_data[sonar_mofn_pkg::MATCH_W-1:0];
                sonar_mofn_pkg::REG_HOLDOFF:
                    holdoff_ticks_next = cfg_wr_data[sonar_mofn_pkg::HOLDOFF_W-1:0];
                sonar_mofn_pkg::REG_ENABLE:    enable_next = cfg_wr_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.op == sonar_mofn_pkg::OP_TICK) begin
                        // Tick: count, arm a request past the holdoff
                        if (tick_inc > {1'b0, holdoff_reg}) begin
                            tick_next    = '0;
                            holdoff_next = '0;
                            request_next = 1'b1;
                        end else begin
                            tick_next = tick_inc;
                        end
                        m_valid_next = 1'b1;
                        m_data_next  = '{sample_taken: 1'b0, obstacle_found: 1'b0,
                                         stop_robot: 1'b0,
                                         request_armed: (tick_inc > {1'b0, holdoff_reg})
                                                        || request_reg};
                    end else if (request_reg) begin
                        // Store sample, then walk the ring
                        mem_we            = 1'b1;
                        vld_next[slot_reg] = 1'b1;
                        slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                           : slot_reg + 1'b1;
                        request_next = 1'b0;
                        scan_next    = '0;
                        near_next    = '0;
                        state_next   = ST_SCAN;
                    end else begin
                        // Sample dropped, nothing armed
                        m_valid_next = 1'b1;
                        m_data_next  = '{sample_taken: 1'b0, obstacle_found: 1'b0,
                                         stop_robot: 1'b0, request_armed: 1'b0};
                    end
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    near_next = near_reg + 1'b1;
                end
                if (scan_reg < CNT_W'(HISTORY_DEPTH)) begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                end else begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{sample_taken: 1'b1, obstacle_found: found,
                                     stop_robot: found && enable_reg, request_armed: 1'b0};
                    if (found) begin
                        vld_next     = '0;
                        slot_next    = '0;
                        tick_next    = '0;
                        holdoff_next = holdoff_ticks_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            dist_thr_reg      <= DW'(30);
            match_thr_reg     <= sonar_mofn_pkg::MATCH_W'(3);
            holdoff_ticks_reg <= sonar_mofn_pkg::HOLDOFF_W'(30);
            enable_reg        <= 1'b0;
            slot_reg          <= '0;
            tick_reg          <= '0;
            holdoff_reg       <= '0;
            request_reg       <= 1'b0;
            vld_reg           <= '0;
            scan_reg          <= '0;
            near_reg          <= '0;
            rd_pend_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            dist_thr_reg      <= dist_thr_next;
            match_thr_reg     <= match_thr_next;
            holdoff_ticks_reg <= holdoff_ticks_next;
            enable_reg        <= enable_next;
            slot_reg          <= slot_next;
            tick_reg          <= tick_next;
            holdoff_reg       <= holdoff_next;
            request_reg       <= request_next;
            vld_reg           <= vld_next;
            scan_reg          <= scan_next;
            near_reg          <= near_next;
            rd_pend_reg       <= rd_pend_next;
            m_valid_reg       <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // History memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[slot_reg] <= s_data.distance;
        end
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

endmodule

@@ tb/sonar_m_of_n_obstacle_detector_tb.sv @@
// ----------------------------------------------------------------------------
// sonar_m_of_n_obstacle_detector_tb
// Self-checking bench for the sonar M-of-N obstacle detector. A queue-fed
// driver sends tick and sample beats with random gaps. A monitor with random
// back-pressure compares every result beat, field by field, against a
// cycle-free software copy of the detector that is advanced on each accepted
// input beat. The run steps through several register settings, the extremes
// among them, and changes them only while the block is idle.
// ----------------------------------------------------------------------------
module sonar_m_of_n_obstacle_detector_tb;

    localparam int HISTORY_DEPTH = 8;
    localparam int SETTLE_CYCLES = HISTORY_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 600000;

    logic                                 aclk         = 1'b0;
    logic                                 aresetn      = 1'b0;
    logic                                 s_valid      = 1'b0;
    logic                                 s_ready;
    sonar_mofn_pkg::in_item_t             s_data       = '0;
    logic                                 m_valid;
    logic                                 m_ready      = 1'b0;
    sonar_mofn_pkg::out_item_t            m_data;
    logic                                 cfg_wr_en    = 1'b0;
    logic [sonar_mofn_pkg::CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [sonar_mofn_pkg::CFG_DAT_W-1:0] cfg_wr_data  = '0;

    // Beats waiting to be sent, and reports the detector owes us
    sonar_mofn_pkg::in_item_t  beats_to_send[$];
    sonar_mofn_pkg::out_item_t expected_reports[$];
    int        error_count = 0;
    bit        no_idle     = 1'b0;
    int        cycle_count = 0;

    // Software copy of the detector: registers
    logic [sonar_mofn_pkg::DIST_W-1:0]    thr_cfg;
    logic [sonar_mofn_pkg::MATCH_W-1:0]   match_cfg;
    logic [sonar_mofn_pkg::HOLDOFF_W-1:0] hold_cfg;
    logic                                 enable_cfg;

    // Software copy of the detector: state
    logic [sonar_mofn_pkg::DIST_W-1:0]    ring [HISTORY_DEPTH];
    int                                   ring_slot;
    logic [sonar_mofn_pkg::TICK_W-1:0]    tick_cnt;
    logic [sonar_mofn_pkg::HOLDOFF_W-1:0] hold_left;
    logic                                 req_armed;

    sonar_m_of_n_obstacle_detector #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Ring wipe done on reset and on every detection
    function automatic void clear_history();
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring[i] = '0;
        end
        ring_slot = 0;
        tick_cnt  = '0;
        hold_left = '0;
    endfunction

    // Advance the detector copy by one input beat; returns the report it owes
    function automatic sonar_mofn_pkg::out_item_t advance_detector(
        sonar_mofn_pkg::in_item_t beat);
        sonar_mofn_pkg::out_item_t rpt;
        int                        near_cnt;
        rpt      = '0;
        near_cnt = 0;
        if (beat.op == sonar_mofn_pkg::OP_TICK) begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt > {1'b0, hold_left}) begin
                hold_left = '0;
                tick_cnt  = '0;
                req_armed = 1'b1;
            end
        end else if (req_armed) begin
            req_armed        = 1'b0;
            rpt.sample_taken = 1'b1;
            ring[ring_slot]  = beat.distance;
            ring_slot        = (ring_slot == HISTORY_DEPTH - 1) ? 0 : ring_slot + 1;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                if (ring[i] != '0 && ring[i] < thr_cfg) near_cnt++;
            end
            if (near_cnt >= int'(match_cfg)) begin
                clear_history();
                hold_left          = hold_cfg;
                rpt.obstacle_found = 1'b1;
                rpt.stop_robot     = enable_cfg;
            end
        end
        rpt.request_armed = req_armed;
        return rpt;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Distance biased toward the threshold edges
    function automatic logic [sonar_mofn_pkg::DIST_W-1:0] pick_distance(
        logic [sonar_mofn_pkg::DIST_W-1:0] thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return (thr > 1) ? sonar_mofn_pkg::DIST_W'($urandom_range(1, int'(thr) - 1))
                             : '0;
        end
        if (r < 50) return '0;
        if (r < 60) return thr;
        if (r < 70) return thr - 1'b1;
        return sonar_mofn_pkg::DIST_W'($urandom);
    endfunction

    // Input side: hold each beat until accepted, then optionally idle
    always @(posedge aclk) begin
        int send_gap;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_reports.push_back(advance_detector(s_data));
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
                s_data   <= beats_to_send.pop_front();
                s_valid  <= 1'b1;
                send_gap = idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: check each beat, stall at random
    always @(posedge aclk) begin
        int                        stall_left;
        sonar_mofn_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result beat %b", m_data);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_data.sample_taken !== want.sample_taken) begin
                        $error("sample_taken: expected %0b, got %0b",
                               want.sample_taken, m_data.sample_taken);
                        error_count++;
                    end
                    if (m_data.obstacle_found !== want.obstacle_found) begin
                        $error("obstacle_found: expected %0b, got %0b",
                               want.obstacle_found, m_data.obstacle_found);
                        error_count++;
                    end
                    if (m_data.stop_robot !== want.stop_robot) begin
                        $error("stop_robot: expected %0b, got %0b",
                               want.stop_robot, m_data.stop_robot);
                        error_count++;
                    end
                    if (m_data.request_armed !== want.request_armed) begin
                        $error("request_armed: expected %0b, got %0b",
                               want.request_armed, m_data.request_armed);
                        error_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    // Register write, mirrored into the detector copy
    task automatic write_reg(logic [sonar_mofn_pkg::CFG_IDX_W-1:0] idx,
                             logic [sonar_mofn_pkg::CFG_DAT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        case (idx)
            sonar_mofn_pkg::REG_DIST_THR:
                thr_cfg    = value[sonar_mofn_pkg::DIST_W-1:0];
            sonar_mofn_pkg::REG_MATCH_THR:
                match_cfg  = value[sonar_mofn_pkg::MATCH_W-1:0];
            sonar_mofn_pkg::REG_HOLDOFF:
                hold_cfg   = value[sonar_mofn_pkg::HOLDOFF_W-1:0];
            sonar_mofn_pkg::REG_ENABLE:
                enable_cfg = value[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_beat(logic op, logic [sonar_mofn_pkg::DIST_W-1:0] dist_val);
        sonar_mofn_pkg::in_item_t beat;
        beat.op       = op;
        beat.distance = dist_val;
        beats_to_send.push_back(beat);
    endtask

    // Mostly tick runs ending in a sample, with stray ticks and samples mixed in
    task automatic queue_random_items(int count, logic [sonar_mofn_pkg::DIST_W-1:0] thr,
                                      int hold);
        int made;
        int run;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 3) != 0) begin
                run = $urandom_range(1, hold + 2);
                repeat (run) begin
                    push_beat(sonar_mofn_pkg::OP_TICK, sonar_mofn_pkg::DIST_W'($urandom));
                end
                push_beat(sonar_mofn_pkg::OP_SAMPLE, pick_distance(thr));
                made += run + 1;
            end else begin
                push_beat($urandom_range(0, 1) ? sonar_mofn_pkg::OP_SAMPLE
                                               : sonar_mofn_pkg::OP_TICK,
                          sonar_mofn_pkg::DIST_W'($urandom));
                made++;
            end
        end
    endtask

    // Block is idle once nothing is queued, in flight or owed
    task automatic wait_idle();
        while (beats_to_send.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stimulus sequence
    initial begin
        logic [sonar_mofn_pkg::DIST_W-1:0] thr;
        int                                hold;
        thr_cfg    = 16'd30;
        match_cfg  = 4'd3;
        hold_cfg   = 7'd30;
        enable_cfg = 1'b0;
        req_armed  = 1'b0;
        clear_history();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: dropped sample, re-arm, zero and boundary distances,
        // detection with stop masked, then a tick with junk distance and a sample dropped in holdoff
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'hFFFF);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h5A5A);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd0);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd29);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd30);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd1);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'hFFFF);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd29);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'hFFFF);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd5);
        wait_idle();

        // Match threshold zero, zero holdoff, stop enabled
        write_reg(sonar_mofn_pkg::REG_ENABLE, 16'd1);
        write_reg(sonar_mofn_pkg::REG_MATCH_THR, 16'd0);
        write_reg(sonar_mofn_pkg::REG_HOLDOFF, 16'd0);
        repeat (32) push_beat(sonar_mofn_pkg::OP_TICK, 16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'h8000);
        push_beat(sonar_mofn_pkg::OP_TICK,   16'h0000);
        push_beat(sonar_mofn_pkg::OP_SAMPLE, 16'd0);
        queue_random_items(60, thr_cfg, 0);
        wait_idle();

        // Match threshold above the ring depth: never detects, ring wraps
        write_reg(sonar_mofn_pkg::REG_MATCH_THR, 16'd15);
        write_reg(sonar_mofn_pkg::REG_DIST_THR, 16'hFFFF);
        queue_random_items(100, 16'hFFFF, 0);
        wait_idle();

        // Zero distance threshold: nothing is near
        write_reg(sonar_mofn_pkg::REG_DIST_THR, 16'd0);
        write_reg(sonar_mofn_pkg::REG_MATCH_THR, 16'd1);
        queue_random_items(60, 16'd0, 0);
        wait_idle();

        // Random settings; junk in the unused upper data bits
        for (int ph = 0; ph < 4; ph++) begin
            thr  = sonar_mofn_pkg::DIST_W'($urandom_range(2, 65535));
            hold = $urandom_range(0, 6);
            no_idle = (ph == 2);
            write_reg(sonar_mofn_pkg::REG_DIST_THR, thr);
            write_reg(sonar_mofn_pkg::REG_MATCH_THR,
                      {12'($urandom), 4'($urandom_range(1, 8))});
            write_reg(sonar_mofn_pkg::REG_HOLDOFF, {9'($urandom), 7'(hold)});
            write_reg(sonar_mofn_pkg::REG_ENABLE,
                      {15'($urandom), 1'($urandom_range(0, 1))});
            queue_random_items(150, thr, hold);
            wait_idle();
        end
        no_idle = 1'b0;

        // Longest holdoff: tick runs of random length, some long enough to outlast it
        write_reg(sonar_mofn_pkg::REG_HOLDOFF, 16'd127);
        write_reg(sonar_mofn_pkg::REG_DIST_THR, 16'hFFFF);
        write_reg(sonar_mofn_pkg::REG_MATCH_THR, 16'd1);
        queue_random_items(300, 16'hFFFF, 127);
        wait_idle();

        error_count += expected_reports.size();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
